FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/tvcrt_pkg.sv
// ---------------------------------------------------------------------------
// tvcrt_pkg
// Types and constants of the CRT shadow-mask 4x pixel expander.
// ---------------------------------------------------------------------------
package tvcrt_pkg;

  typedef struct packed {
    logic [23:0] pixel;
    logic [23:0] right_pixel;
    logic        col_odd;
  } in_t;

  typedef struct packed {
    logic [23:0] out_pixel;
    logic [1:0]  out_row;
    logic [1:0]  out_col;
    logic        last;
  } out_t;

  // Everything the block emitter needs to build one 4x4 block.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] sr;
    logic [7:0] sg;
    logic [7:0] sb;
    logic [7:0] blr;
    logic [7:0] blg;
    logic [7:0] blb;
    logic       odd;
  } shade_t;

  // Handshake between the shading pipeline and the emitter.
  typedef struct packed {
    logic valid;
    logic ready;
  } pipe_hs_t;

  localparam logic [6:0]  FACTOR_BASE = 7'd50;
  localparam logic [6:0]  BLEND_BIAS  = 7'd10;

  // Division by a constant as multiply and shift; exact over the ranges used.
  localparam logic [12:0] RECIP51     = 13'd5141;   // 2^18 / 51, rounded up
  localparam int          SHIFT51     = 18;
  localparam logic [14:0] RECIP100    = 15'd20972;  // 2^21 / 100, rounded up
  localparam int          SHIFT100    = 21;
  localparam logic [16:0] RECIP200    = 17'd83887;  // 2^24 / 200, rounded up
  localparam int          SHIFT200    = 24;

  localparam logic [1:0]  DARK_ROW_ODD  = 2'd0;
  localparam logic [1:0]  DARK_ROW_EVEN = 2'd2;
  localparam logic [1:0]  LAST_ROW      = 2'd3;
  localparam logic [1:0]  LAST_COL      = 2'd3;
  localparam logic [3:0]  LAST_BEAT     = 4'd15;

endpackage

FILE: hdl/tvcrt_shade_pipe.sv
// ---------------------------------------------------------------------------
// tvcrt_shade_pipe
// Four-stage pipeline that computes the light factor, the scaled channels
// and the blended channels of one source pixel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tvcrt_shade_pipe
  import tvcrt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_word,
  output pipe_hs_t hs,
  input  logic   drain,
  output shade_t shade
);

  logic [4:1] v;
  logic [4:1] en;

  // Stage 1: channel split and sums.
  logic [7:0]  r1, g1, b1;
  logic [8:0]  nr1, ng1, nb1;
  logic [10:0] sum2_1;
  logic        odd1;
  // Stage 2: light factor.
  logic [7:0]  r2, g2, b2;
  logic [8:0]  nr2, ng2, nb2;
  logic [6:0]  f2;
  logic        odd2;
  // Stage 3: raw products.
  logic [7:0]  r3, g3, b3;
  logic [14:0] pr3, pg3, pb3;
  logic [15:0] nr3, ng3, nb3;
  logic        odd3;

  logic [9:0]  sum_c;
  logic [23:0] fq_c;
  logic [6:0]  fb_c;
  logic [29:0] qr_c, qg_c, qb_c;
  logic [32:0] br_c, bg_c, bb_c;

  // A stage loads when it is empty or its word moves on.
  assign en[4]    = !v[4] || drain;
  assign en[3]    = !v[3] || en[4];
  assign en[2]    = !v[2] || en[3];
  assign en[1]    = !v[1] || en[2];
  assign in_ready = en[1];
  assign hs.valid = v[4];
  assign hs.ready = drain;

  assign sum_c = 10'(in_word.pixel[23:16]) + 10'(in_word.pixel[15:8])
               + 10'(in_word.pixel[7:0]);
  assign fq_c  = 24'(sum2_1) * 24'(RECIP51);
  assign fb_c  = f2 + BLEND_BIAS;
  assign qr_c  = 30'(pr3) * 30'(RECIP100);
  assign qg_c  = 30'(pg3) * 30'(RECIP100);
  assign qb_c  = 30'(pb3) * 30'(RECIP100);
  assign br_c  = 33'(nr3) * 33'(RECIP200);
  assign bg_c  = 33'(ng3) * 33'(RECIP200);
  assign bb_c  = 33'(nb3) * 33'(RECIP200);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1     <= in_word.pixel[23:16];
      g1     <= in_word.pixel[15:8];
      b1     <= in_word.pixel[7:0];
      nr1    <= 9'(in_word.pixel[23:16]) + 9'(in_word.right_pixel[23:16]);
      ng1    <= 9'(in_word.pixel[15:8]) + 9'(in_word.right_pixel[15:8]);
      nb1    <= 9'(in_word.pixel[7:0]) + 9'(in_word.right_pixel[7:0]);
      sum2_1 <= {sum_c, 1'b0};
      odd1   <= in_word.col_odd;
    end
    if (en[2]) begin
      r2   <= r1;
      g2   <= g1;
      b2   <= b1;
      nr2  <= nr1;
      ng2  <= ng1;
      nb2  <= nb1;
      f2   <= FACTOR_BASE + 7'(fq_c[SHIFT51 +: 6]);
      odd2 <= odd1;
    end
    if (en[3]) begin
      r3   <= r2;
      g3   <= g2;
      b3   <= b2;
      pr3  <= 15'(r2) * 15'(f2);
      pg3  <= 15'(g2) * 15'(f2);
      pb3  <= 15'(b2) * 15'(f2);
      nr3  <= 16'(nr2) * 16'(fb_c);
      ng3  <= 16'(ng2) * 16'(fb_c);
      nb3  <= 16'(nb2) * 16'(fb_c);
      odd3 <= odd2;
    end
    if (en[4]) begin
      shade.r   <= r3;
      shade.g   <= g3;
      shade.b   <= b3;
      shade.sr  <= qr_c[SHIFT100 +: 8];
      shade.sg  <= qg_c[SHIFT100 +: 8];
      shade.sb  <= qb_c[SHIFT100 +: 8];
      shade.blr <= br_c[SHIFT200 +: 8];
      shade.blg <= bg_c[SHIFT200 +: 8];
      shade.blb <= bb_c[SHIFT200 +: 8];
      shade.odd <= odd3;
    end
  end

  // The entry stage only refuses a word when it holds one that cannot move.
  `ASSERT_IMPLY(a_busy_full, clk, rst, !in_ready, v[1] && v[2] && v[3] && v[4] && !drain)
  // A finished word that is not drained stays put.
  `ASSERT_NEXT(a_hold_out, clk, rst, v[4] && !drain, v[4])

endmodule

FILE: hdl/tv_crt_4x_pixel_expand.sv
// ---------------------------------------------------------------------------
// tv_crt_4x_pixel_expand
// Expands each source pixel into a 4x4 block of shadow-mask tinted pixels.
// ---------------------------------------------------------------------------
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------------
//  input    | start, busy, item      | word taken when start && !busy
//  result   | strobe, result         | one word per cycle while strobe high
//
// Each source pixel yields sixteen result words on consecutive cycles; with
// its beat counter and single result register, the emitter takes a new
// block only when idle or on the final beat. An input word passes the
// pipeline stages, the block register and the result register before its
// first result word is on the result ports. Up to four more input words
// are taken while a block is being emitted, then busy rises until the
// emitter frees the pipeline. Reset clears all valid bits and the emitter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tv_crt_4x_pixel_expand
  import tvcrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic strobe,
  output out_t result
);

  pipe_hs_t   hs;
  logic       in_ready;
  logic       take;
  shade_t     shade;
  shade_t     blk;
  logic       act;
  logic [3:0] cnt;
  logic [1:0] row;
  logic [1:0] col;
  logic [1:0] dark_row;
  logic [23:0] pix;

  assign busy = !in_ready;

  tvcrt_shade_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .in_ready (in_ready),
    .in_word  (item),
    .hs       (hs),
    .drain    (take),
    .shade    (shade)
  );

  // A new block loads when the emitter is idle or on its final beat.
  assign take = hs.valid && (!act || cnt == LAST_BEAT);

  assign row      = cnt[3:2];
  assign col      = cnt[1:0];
  assign dark_row = blk.odd ? DARK_ROW_ODD : DARK_ROW_EVEN;

  always_comb begin
    if (row == dark_row) begin
      pix = {blk.sr, blk.sg, blk.sb};
    end else begin
      unique case (col)
        2'd0:    pix = {blk.r, blk.sg, blk.sb};
        2'd1:    pix = {blk.sr, blk.g, blk.sb};
        2'd2:    pix = {blk.sr, blk.sg, blk.b};
        default: pix = {blk.blr, blk.blg, blk.blb};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act    <= 1'b0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= act;
      act    <= take || (act && cnt != LAST_BEAT);
      // The counter wraps to zero on the final beat, ready for the next block.
      if (act) cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) blk <= shade;
    if (act) begin
      result.out_pixel <= pix;
      result.out_row   <= row;
      result.out_col   <= col;
      result.last      <= (cnt == LAST_BEAT);
    end
  end

  `ASSERT_IMPLY(a_last_pos, clk, rst, strobe && result.last,
                result.out_row == LAST_ROW && result.out_col == LAST_COL)
  `ASSERT_NEXT(a_act_strobe, clk, rst, act, strobe)
  `ASSERT_NEXT(a_block_contig, clk, rst, strobe && !result.last, strobe)
  // The emitter only drains the pipeline when a finished word is waiting.
  `ASSERT_IMPLY(a_take_valid, clk, rst, hs.ready, hs.valid)

endmodule
